>>> hdl/mau_pkg.sv
// Shared types and constants for the modular arithmetic unit.
package mau_pkg;

  localparam logic [30:0] ModulusReset = 31'd1000000007;

  typedef enum logic [2:0] {
    ACT_REDUCE = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_SUB    = 3'd2,
    ACT_MUL    = 3'd3,
    ACT_DIV    = 3'd4,
    ACT_NEG    = 3'd5,
    ACT_INC    = 3'd6,
    ACT_DEC    = 3'd7
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_FIX_A,
    ST_FIX_B,
    ST_DECIDE,
    ST_EUC_DIV,
    ST_EUC_UPD,
    ST_EUC_FIX,
    ST_MUL,
    ST_OUT
  } state_t;

endpackage

>>> hdl/modular_arithmetic_unit.sv
// Modular arithmetic unit: top level with sequencer, shared reducer, divider and multiplier.
//
// Input beats on s_axis carry action and two signed operands; each yields one
// output beat on m_axis with the residue and a not_invertible flag.
// The modulus is written through cfg_we/cfg_wdata; the user must do so only
// while the block is idle, as the block itself does not enforce it.
// One item at a time: each operand is reduced bit-serially in the shared
// reducer, then gets a sign fix. The simple actions are computed from the
// reduced residues in the decide state; multiply then runs the serial
// multiplier. Divide runs extended Euclid: each quotient comes from a
// restoring division that accumulates q*t1 mod m alongside, followed by the
// update and fix states; a unit final remainder leads to a multiply of the
// first residue by the inverse. The next input beat can be taken at the
// earliest in the cycle after the output beat.
// The result sits in an output register until taken; s_axis_tready stays
// low until then. Reset returns the sequencer to idle and loads the modulus
// reset value 1000000007.
module modular_arithmetic_unit #(
  parameter int OPERAND_BITS = 64,
  parameter int MODULUS_BITS = 31
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [30:0]                 cfg_wdata,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // action[2:0], operand_a[66:3], operand_b[130:67], zero fill to 136
  input  logic [135:0]                s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // residue[30:0], not_invertible[31]
  output logic [31:0]                 m_axis_tdata
);
  localparam int OB = OPERAND_BITS;
  localparam int MB = MODULUS_BITS;
  localparam int CB = $clog2(MB + 2);

  mau_pkg::state_t state, state_next;

  logic [30:0]    modulus;
  logic [MB-1:0]  m;
  logic [2:0]     action;
  logic [OB-1:0]  opb;
  logic           nega, negb;
  logic [MB-1:0]  ra, rb;
  logic [30:0]    res_q;
  logic           flag_q;

  // Reducer
  logic           red_start;
  logic [OB-1:0]  red_val;
  logic [MB-1:0]  red_rem;
  logic           red_done;

  // Multiplier
  logic           mul_start;
  logic [MB-1:0]  mul_x, mul_y, mul_p;
  logic           mul_done;

  // Euclid registers: r0, r1 remainders, t0, t1 coefficients mod m
  logic [MB:0]    r0, r1;
  logic [MB-1:0]  t0, t1;
  logic [MB:0]    quo, drem;
  logic [CB-1:0]  dcnt;
  logic [MB:0]    qt_acc;
  logic [MB:0]    shifted;
  logic [MB+1:0]  tsum;

  assign m = modulus[MB-1:0];

  always_ff @(posedge clk) begin
    if (rst) modulus <= mau_pkg::ModulusReset;
    else if (cfg_we) modulus <= cfg_wdata;
  end

  function automatic logic [OB-1:0] mag(input logic [OB-1:0] v);
    return v[OB-1] ? (~v + 1'b1) : v;
  endfunction

  assign red_val = (state == mau_pkg::ST_IDLE) ? mag(s_axis_tdata[3 +: OB]) : mag(opb);

  mau_reducer #(.W(OB), .MB(MB)) u_red (
    .clk(clk), .start(red_start), .value(red_val), .m(m),
    .rem(red_rem), .done(red_done)
  );

  mau_mulmod #(.MB(MB)) u_mul (
    .clk(clk), .start(mul_start), .x(mul_x), .y(mul_y), .m(m),
    .prod(mul_p), .done(mul_done)
  );

  assign mul_x = ra;
  assign mul_y = (action == mau_pkg::ACT_DIV) ? t0 : rb;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mau_pkg::ST_IDLE:    if (s_axis_tvalid) state_next = mau_pkg::ST_RED_A;
      mau_pkg::ST_RED_A:   if (red_done) state_next = mau_pkg::ST_FIX_A;
      mau_pkg::ST_FIX_A:   state_next = mau_pkg::ST_RED_B;
      mau_pkg::ST_RED_B:   if (red_done) state_next = mau_pkg::ST_FIX_B;
      mau_pkg::ST_FIX_B:   state_next = mau_pkg::ST_DECIDE;
      mau_pkg::ST_DECIDE: begin
        if (m < MB'(2)) state_next = mau_pkg::ST_OUT;
        else if (action == mau_pkg::ACT_MUL) state_next = mau_pkg::ST_MUL;
        else if (action == mau_pkg::ACT_DIV)
          state_next = (rb == '0) ? mau_pkg::ST_OUT : mau_pkg::ST_EUC_DIV;
        else state_next = mau_pkg::ST_OUT;
      end
      mau_pkg::ST_EUC_DIV: if (dcnt == '0) state_next = mau_pkg::ST_EUC_UPD;
      mau_pkg::ST_EUC_UPD: state_next = mau_pkg::ST_EUC_FIX;
      mau_pkg::ST_EUC_FIX: begin
        if (r1 != '0) state_next = mau_pkg::ST_EUC_DIV;
        else if (r0 == (MB+1)'(1)) state_next = mau_pkg::ST_MUL;
        else state_next = mau_pkg::ST_OUT;
      end
      mau_pkg::ST_MUL:     if (mul_done) state_next = mau_pkg::ST_OUT;
      mau_pkg::ST_OUT:     if (m_axis_tready) state_next = mau_pkg::ST_IDLE;
      default:             state_next = mau_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    s_axis_tready = (state == mau_pkg::ST_IDLE);
    m_axis_tvalid = (state == mau_pkg::ST_OUT);
    m_axis_tdata  = {flag_q, res_q};
    red_start     = (state == mau_pkg::ST_IDLE && s_axis_tvalid) ||
                    (state == mau_pkg::ST_FIX_A);
    mul_start     = (state == mau_pkg::ST_DECIDE && action == mau_pkg::ACT_MUL &&
                     m >= MB'(2)) ||
                    (state == mau_pkg::ST_EUC_FIX && r1 == '0 && r0 == (MB+1)'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) state <= mau_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Restoring division step on r0 / r1, and q*t1 accumulated mod m alongside.
  assign shifted = {drem[MB-1:0], quo[MB]};
  // t0 - q*t1 mod m, where qt_acc holds q*t1 mod m
  assign tsum = {2'b0, t0} + {1'b0, m} - {1'b0, qt_acc};

  // Arithmetic of the simple actions, computed from reduced residues.
  function automatic logic [MB-1:0] addm(input logic [MB:0] s, input logic [MB-1:0] mm);
    return (s >= {1'b0, mm}) ? MB'(s - {1'b0, mm}) : s[MB-1:0];
  endfunction

  always_ff @(posedge clk) begin
    case (state)
      mau_pkg::ST_IDLE: if (s_axis_tvalid) begin
        action <= s_axis_tdata[2:0];
        opb    <= s_axis_tdata[67 +: OB];
        nega   <= s_axis_tdata[3 + OB - 1];
        negb   <= s_axis_tdata[67 + OB - 1];
        flag_q <= 1'b0;
        res_q  <= '0;
      end
      mau_pkg::ST_FIX_A: ra <= (nega && red_rem != '0) ? m - red_rem : red_rem;
      mau_pkg::ST_FIX_B: rb <= (negb && red_rem != '0) ? m - red_rem : red_rem;
      mau_pkg::ST_DECIDE: begin
        r0 <= {1'b0, m};
        r1 <= {1'b0, rb};
        t0 <= '0;
        t1 <= MB'(1);
        quo <= {1'b0, m};
        drem <= '0;
        qt_acc <= '0;
        dcnt <= CB'(MB + 1);
        if (m < MB'(2)) res_q <= '0;
        else begin
          case (action)
            mau_pkg::ACT_REDUCE: res_q <= 31'(ra);
            mau_pkg::ACT_ADD:    res_q <= 31'(addm({1'b0, ra} + {1'b0, rb}, m));
            mau_pkg::ACT_SUB:    res_q <= 31'(addm({1'b0, ra} + {1'b0, m - rb}, m));
            mau_pkg::ACT_NEG:    res_q <= 31'(addm({1'b0, m - ra}, m));
            mau_pkg::ACT_INC:    res_q <= 31'(addm({1'b0, ra} + (MB+1)'(1), m));
            mau_pkg::ACT_DEC:    res_q <= 31'(addm({1'b0, ra} + {1'b0, m - MB'(1)}, m));
            default:             res_q <= '0;
          endcase
        end
      end
      mau_pkg::ST_EUC_DIV: if (dcnt != '0) begin
        // quotient bits come out MSB first; accumulate q*t1 mod m by Horner
        quo    <= {quo[MB-1:0], shifted >= r1};
        drem   <= (shifted >= r1) ? shifted - r1 : shifted;
        qt_acc <= {1'b0, addm({1'b0, addm({qt_acc[MB-1:0], 1'b0}, m)} +
                   ((shifted >= r1) ? {1'b0, t1} : '0), m)};
        dcnt   <= dcnt - 1'b1;
      end
      mau_pkg::ST_EUC_UPD: begin
        r0 <= r1;
        r1 <= drem;
        t0 <= t1;
        t1 <= addm(tsum[MB:0], m);
      end
      mau_pkg::ST_EUC_FIX: begin
        quo    <= r0;
        drem   <= '0;
        qt_acc <= '0;
        dcnt   <= CB'(MB + 1);
        if (r1 == '0 && r0 != (MB+1)'(1)) begin
          flag_q <= 1'b1;
          res_q  <= '0;
        end
      end
      mau_pkg::ST_MUL: if (mul_done) res_q <= 31'(mul_p);
      default: ;
    endcase
  end
endmodule

>>> hdl/mau_reducer.sv
// Bit-serial reduction of an unsigned value modulo m, one bit per cycle, MSB first.
module mau_reducer #(
  parameter int W  = 64,
  parameter int MB = 31
) (
  input  logic          clk,
  input  logic          start,
  input  logic [W-1:0]  value,
  input  logic [MB-1:0] m,
  output logic [MB-1:0] rem,
  output logic          done
);
  logic [W-1:0]             shreg;
  logic [$clog2(W+1)-1:0]   cnt;
  logic [MB:0]              dbl;
  logic                     busy;

  assign dbl  = {rem, shreg[W-1]};
  assign done = busy && (cnt == '0);

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= value;
      rem   <= '0;
      cnt   <= ($clog2(W+1))'(W);
      busy  <= 1'b1;
    end else if (busy && cnt != '0) begin
      shreg <= {shreg[W-2:0], 1'b0};
      rem   <= (dbl >= {1'b0, m}) ? MB'(dbl - {1'b0, m}) : dbl[MB-1:0];
      cnt   <= cnt - 1'b1;
    end else begin
      busy  <= 1'b0;
    end
  end
endmodule

>>> hdl/mau_mulmod.sv
// Serial modular multiplier: double-and-add over the bits of y, MSB first.
module mau_mulmod #(
  parameter int MB = 31
) (
  input  logic          clk,
  input  logic          start,
  input  logic [MB-1:0] x,
  input  logic [MB-1:0] y,
  input  logic [MB-1:0] m,
  output logic [MB-1:0] prod,
  output logic          done
);
  logic [MB-1:0]           ysh;
  logic [$clog2(MB+1)-1:0] cnt;
  logic                    busy;
  logic [MB:0]             d1, d2;
  logic [MB-1:0]           r1;

  assign d1   = {prod, 1'b0};
  assign r1   = (d1 >= {1'b0, m}) ? MB'(d1 - {1'b0, m}) : d1[MB-1:0];
  assign d2   = {1'b0, r1} + {1'b0, x};
  assign done = busy && (cnt == '0);

  always_ff @(posedge clk) begin
    if (start) begin
      ysh  <= y;
      prod <= '0;
      cnt  <= ($clog2(MB+1))'(MB);
      busy <= 1'b1;
    end else if (busy && cnt != '0) begin
      ysh  <= {ysh[MB-2:0], 1'b0};
      if (ysh[MB-1])
        prod <= (d2 >= {1'b0, m}) ? MB'(d2 - {1'b0, m}) : d2[MB-1:0];
      else
        prod <= r1;
      cnt  <= cnt - 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end
endmodule

>>> hdl/mau_checker.sv
// Port-level checker for the modular arithmetic unit, bound to the top level.
module mau_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input accepted while result pending");
  a_start: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("result appeared right after accept");
  a_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[31] |-> m_axis_tdata[30:0] == '0)
    else $error("not_invertible with nonzero residue");
endmodule

bind modular_arithmetic_unit mau_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

>>> tb/tb_modular_arithmetic_unit.sv
// Self-checking testbench for the modular arithmetic unit with a scoreboard class.
module tb_modular_arithmetic_unit;

  typedef struct packed {
    logic [30:0] residue;
    logic        not_invertible;
  } mod_result_t;

  class residue_scoreboard;
    mod_result_t pending[$];
    logic [30:0] modulus;
    int errors;

    function new();
      modulus = mau_pkg::ModulusReset;
      errors = 0;
    endfunction

    // Mathematical residue of a signed 64-bit operand.
    function logic [63:0] operand_residue(logic [63:0] raw, logic [63:0] m);
      logic [63:0] mag;
      logic [63:0] r;
      if (raw[63]) begin
        mag = ~raw + 64'd1;
        r = mag % m;
        return (r == 0) ? 64'd0 : m - r;
      end
      return raw % m;
    endfunction

    // Returns 1 and the inverse when gcd(b, m) is one.
    function bit find_inverse(logic [63:0] b, logic [63:0] m,
                              output logic [63:0] inv);
      longint r0, r1, t0, t1, q, rn, tn;
      r0 = m; r1 = b; t0 = 0; t1 = 1;
      inv = 0;
      while (r1 != 0) begin
        q = r0 / r1;
        rn = r0 - q * r1;
        tn = t0 - q * t1;
        r0 = r1; r1 = rn;
        t0 = t1; t1 = tn;
      end
      if (r0 != 1) return 0;
      if (t0 < 0) t0 += longint'(m);
      inv = 64'(t0) % m;
      return 1;
    endfunction

    function void note_input(mau_pkg::action_t act, logic [63:0] opa, logic [63:0] opb);
      logic [63:0] m, a, b, inv, res;
      mod_result_t exp_res;
      m = {33'd0, modulus};
      res = 0;
      exp_res.not_invertible = 1'b0;
      if (m >= 2) begin
        a = operand_residue(opa, m);
        b = operand_residue(opb, m);
        case (act)
          mau_pkg::ACT_REDUCE: res = a;
          mau_pkg::ACT_ADD:    res = (a + b) % m;
          mau_pkg::ACT_SUB:    res = (a + m - b) % m;
          mau_pkg::ACT_MUL:    res = (a * b) % m;
          mau_pkg::ACT_DIV: begin
            if (b == 0) res = 0;
            else if (find_inverse(b, m, inv)) res = (a * inv) % m;
            else begin
              res = 0;
              exp_res.not_invertible = 1'b1;
            end
          end
          mau_pkg::ACT_NEG:    res = (m - a) % m;
          mau_pkg::ACT_INC:    res = (a + 1) % m;
          default:             res = (a + m - 1) % m;
        endcase
      end
      exp_res.residue = res[30:0];
      pending.push_back(exp_res);
    endfunction

    function void check_result(logic [31:0] data);
      mod_result_t exp_res;
      if (pending.size() == 0) begin
        $error("unexpected result beat %h", data);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (data[30:0] !== exp_res.residue) begin
        $error("residue: expected %0d, actual %0d", exp_res.residue, data[30:0]);
        errors++;
      end
      if (data[31] !== exp_res.not_invertible) begin
        $error("not_invertible: expected %0d, actual %0d",
               exp_res.not_invertible, data[31]);
        errors++;
      end
    endfunction
  endclass

  localparam int WatchdogLimit = 200000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [30:0]  cfg_wdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;

  residue_scoreboard sb = new();
  int idle_cycles = 0;

  modular_arithmetic_unit DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  always #4 clk = ~clk;

  // Result side: random stalls, check on every accepted beat.
  initial begin
    int stall;
    @(negedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata);
      @(negedge clk);
    end
  end

  // Watchdog on cycles with no accepted beat.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Leaves tvalid high after the beat; the next call or the caller drops it.
  task automatic send_item(mau_pkg::action_t act, logic [63:0] opa, logic [63:0] opb,
                           bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata <= {5'd0, opb, opa, act};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(act, opa, opb);
    @(negedge clk);
  endtask

  // Waits for the block to drain, then writes a new modulus.
  task automatic write_modulus(logic [30:0] value);
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.modulus = value;
  endtask

  function automatic logic [63:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return 64'(signed'($urandom_range(0, 20)) - 10);
      3: return {32'd0, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_phase(int count);
    bit burst;
    for (int i = 0; i < count; i++) begin
      burst = ((i / 40) % 3 == 0);
      send_item(mau_pkg::action_t'($urandom_range(0, 7)), rand_operand(), rand_operand(),
                burst);
    end
  endtask

  initial begin
    logic [30:0] moduli[6];
    moduli = '{31'd2, 31'h7fff_ffff, 31'd12, 31'd1000000007, 31'd97, 31'd360360};
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Extremes of the operands and every action, including zero divisors.
    for (int k = 0; k < 8; k++)
      send_item(mau_pkg::action_t'(k), 64'h8000_0000_0000_0000,
                64'h7fff_ffff_ffff_ffff, 0);
    send_item(mau_pkg::ACT_DIV, 64'd5, 64'd0, 0);
    send_item(mau_pkg::ACT_DIV, 64'hffff_ffff_ffff_ffff, 64'd1000000007, 0);
    send_item(mau_pkg::ACT_MUL, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 0);
    send_item(mau_pkg::ACT_DEC, 64'd0, 64'd0, 0);
    send_item(mau_pkg::ACT_INC, 64'd1000000006, 64'd0, 0);
    random_phase(200);

    foreach (moduli[j]) begin
      write_modulus(moduli[j]);
      // A composite modulus exercises divisors without an inverse.
      if (moduli[j] == 31'd12) begin
        send_item(mau_pkg::ACT_DIV, 64'd7, 64'd4, 0);
        send_item(mau_pkg::ACT_DIV, 64'd7, 64'd5, 0);
        send_item(mau_pkg::ACT_DIV, 64'd7, 64'hffff_ffff_ffff_fffa, 0);
      end
      random_phase(210);
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
